// ===== rtl/bmf_pkg.sv =====
// ----------------------------------------------------------------------------
// bmf_pkg
// Shared types, constants and helpers of the 3x3 box mean filter.
// ----------------------------------------------------------------------------
package bmf_pkg;

  localparam int PIX_W        = 8;
  localparam int CH_N         = 3;
  localparam int RGB_W        = PIX_W * CH_N;
  localparam int COL_W        = 10;
  localparam int ROW_W        = 12;
  localparam int CFG_IDX_W    = 8;
  localparam int CFG_DATA_W   = 16;
  localparam int WIDTH_CFG_W  = 11;
  localparam int HEIGHT_CFG_W = 13;
  localparam int WIDTH_RESET  = 640;
  localparam int HEIGHT_RESET = 480;
  localparam int DIM_MIN      = 3;

  // one column of three bytes, and nine of them
  localparam int CSUM_W = 10;
  localparam int BSUM_W = 12;

  // floor(s / 9) == (s * 3641) >> 15 for every s below 32768
  localparam int DIV9_MUL   = 3641;
  localparam int DIV9_SHIFT = 15;
  localparam int DIV9_PW    = 24;

  // result slots of one pixel, in emission order
  localparam int SLOT_MEAN   = 0;
  localparam int SLOT_RIGHT  = 1;
  localparam int SLOT_BOTTOM = 2;
  localparam int SLOT_N      = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_IMAGE_WIDTH  = 8'd0,
    CFG_IMAGE_HEIGHT = 8'd1
  } cfg_reg_e;

  // chan0 in bits 7:0, chan1 in 15:8, chan2 in 23:16
  typedef logic [RGB_W-1:0] rgb_t;

  typedef struct packed {
    rgb_t             pix;
    rgb_t             up;
    rgb_t             mid;
    logic [COL_W-1:0] col;
    logic [ROW_W-1:0] row;
    logic             emit_mean;
    logic             emit_right;
    logic             emit_bottom;
    logic             border;
  } bmf_item_t;

  function automatic logic [PIX_W-1:0] div9(input logic [BSUM_W-1:0] s);
    logic [DIV9_PW-1:0] p;
    p = DIV9_PW'(s) * DIV9_PW'(DIV9_MUL);
    return p[DIV9_SHIFT +: PIX_W];
  endfunction

endpackage

// ===== rtl/bmf_if.sv =====
// ----------------------------------------------------------------------------
// bmf interfaces
// Pixel input, result output and configuration write channels.
// ----------------------------------------------------------------------------
interface bmf_pix_if;
  logic                       valid;
  logic                       ready;
  logic [bmf_pkg::PIX_W-1:0]  chan0_in;
  logic [bmf_pkg::PIX_W-1:0]  chan1_in;
  logic [bmf_pkg::PIX_W-1:0]  chan2_in;

  modport source (output valid, chan0_in, chan1_in, chan2_in, input ready);
  modport sink   (input valid, chan0_in, chan1_in, chan2_in, output ready);
endinterface

interface bmf_res_if;
  logic                       valid;
  logic                       ready;
  logic [bmf_pkg::PIX_W-1:0]  chan0_out;
  logic [bmf_pkg::PIX_W-1:0]  chan1_out;
  logic [bmf_pkg::PIX_W-1:0]  chan2_out;
  logic [bmf_pkg::COL_W-1:0]  out_col;
  logic [bmf_pkg::ROW_W-1:0]  out_row;
  logic                       run_last;

  modport source (output valid, chan0_out, chan1_out, chan2_out, out_col, out_row,
                  run_last, input ready);
  modport sink   (input valid, chan0_out, chan1_out, chan2_out, out_col, out_row,
                  run_last, output ready);
endinterface

interface bmf_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [bmf_pkg::CFG_IDX_W-1:0]   index;
  logic [bmf_pkg::CFG_DATA_W-1:0]  data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== rtl/bmf_ram.sv =====
// ----------------------------------------------------------------------------
// bmf_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module bmf_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/bmf_emit.sv =====
// ----------------------------------------------------------------------------
// bmf_emit
// Window column sums, mean and border selection, and the result register
// that sends up to three results of a pixel, one word per cycle while ready.
// ----------------------------------------------------------------------------
module bmf_emit (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  bmf_pkg::bmf_item_t  item_i,
  input  logic                load_valid_i,
  output logic                load_ready_o,
  bmf_res_if.source           res_o
);

  localparam int PW = bmf_pkg::PIX_W;

  // per channel, sums of the three window columns (oldest first)
  logic [bmf_pkg::CSUM_W-1:0] csum_q [bmf_pkg::CH_N][3];
  bmf_pkg::rgb_t              mid_right_q;
  bmf_pkg::rgb_t              center_q;
  bmf_pkg::rgb_t              pix_q;
  logic [bmf_pkg::COL_W-1:0]  col_q;
  logic [bmf_pkg::ROW_W-1:0]  row_q;
  logic                       border_q;
  logic [bmf_pkg::SLOT_N-1:0] pend_q;
  logic [bmf_pkg::SLOT_N-1:0] pend_d;

  logic                       out_valid_q;
  logic                       out_valid_d;
  bmf_pkg::rgb_t              out_pix_q;
  logic [bmf_pkg::COL_W-1:0]  out_col_q;
  logic [bmf_pkg::ROW_W-1:0]  out_row_q;
  logic                       out_last_q;

  logic [bmf_pkg::SLOT_N-1:0] sel;
  logic [bmf_pkg::SLOT_N-1:0] rest;
  logic                       move;
  logic                       load;
  bmf_pkg::rgb_t              mean_pix;
  bmf_pkg::rgb_t              res_pix;
  logic [bmf_pkg::COL_W-1:0]  res_col;
  logic [bmf_pkg::ROW_W-1:0]  res_row;

  always_comb begin
    sel = '0;
    if (pend_q[bmf_pkg::SLOT_MEAN]) begin
      sel[bmf_pkg::SLOT_MEAN] = 1'b1;
    end else if (pend_q[bmf_pkg::SLOT_RIGHT]) begin
      sel[bmf_pkg::SLOT_RIGHT] = 1'b1;
    end else if (pend_q[bmf_pkg::SLOT_BOTTOM]) begin
      sel[bmf_pkg::SLOT_BOTTOM] = 1'b1;
    end
  end

  assign rest         = pend_q & ~sel;
  assign move         = (pend_q != '0) && (!out_valid_q || res_o.ready);
  assign load_ready_o = (pend_q == '0) || (move && (rest == '0));
  assign load         = load_valid_i && load_ready_o;

  always_comb begin
    logic [bmf_pkg::BSUM_W-1:0] box;
    mean_pix = '0;
    for (int ch = 0; ch < bmf_pkg::CH_N; ch++) begin
      box = bmf_pkg::BSUM_W'(csum_q[ch][0]) + bmf_pkg::BSUM_W'(csum_q[ch][1])
          + bmf_pkg::BSUM_W'(csum_q[ch][2]);
      mean_pix[ch*PW +: PW] = bmf_pkg::div9(box);
    end
  end

  always_comb begin
    if (sel[bmf_pkg::SLOT_MEAN]) begin
      res_pix = border_q ? center_q : mean_pix;
      res_col = col_q - bmf_pkg::COL_W'(1);
      res_row = row_q - bmf_pkg::ROW_W'(1);
    end else if (sel[bmf_pkg::SLOT_RIGHT]) begin
      res_pix = mid_right_q;
      res_col = col_q;
      res_row = row_q - bmf_pkg::ROW_W'(1);
    end else begin
      res_pix = pix_q;
      res_col = col_q;
      res_row = row_q;
    end
  end

  always_comb begin
    pend_d = pend_q;
    if (load) begin
      pend_d[bmf_pkg::SLOT_MEAN]   = item_i.emit_mean;
      pend_d[bmf_pkg::SLOT_RIGHT]  = item_i.emit_right;
      pend_d[bmf_pkg::SLOT_BOTTOM] = item_i.emit_bottom;
    end else if (move) begin
      pend_d = rest;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (move) begin
      out_valid_d = 1'b1;
    end else if (res_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      pend_q      <= pend_d;
      out_valid_q <= out_valid_d;
    end
  end

  // window shift: new right column is rows r-2, r-1, r
  always_ff @(posedge clk_i) begin
    if (load) begin
      for (int ch = 0; ch < bmf_pkg::CH_N; ch++) begin
        csum_q[ch][0] <= csum_q[ch][1];
        csum_q[ch][1] <= csum_q[ch][2];
        csum_q[ch][2] <= bmf_pkg::CSUM_W'(item_i.up[ch*PW +: PW])
                       + bmf_pkg::CSUM_W'(item_i.mid[ch*PW +: PW])
                       + bmf_pkg::CSUM_W'(item_i.pix[ch*PW +: PW]);
      end
      center_q    <= mid_right_q;
      mid_right_q <= item_i.mid;
      pix_q       <= item_i.pix;
      col_q       <= item_i.col;
      row_q       <= item_i.row;
      border_q    <= item_i.border;
    end
    if (move) begin
      out_pix_q  <= res_pix;
      out_col_q  <= res_col;
      out_row_q  <= res_row;
      out_last_q <= (rest == '0);
    end
  end

  assign res_o.valid     = out_valid_q;
  assign res_o.chan0_out = out_pix_q[0*PW +: PW];
  assign res_o.chan1_out = out_pix_q[1*PW +: PW];
  assign res_o.chan2_out = out_pix_q[2*PW +: PW];
  assign res_o.out_col   = out_col_q;
  assign res_o.out_row   = out_row_q;
  assign res_o.run_last  = out_last_q;

endmodule

// ===== rtl/box_mean_filter_3x3_rgb.sv =====
// ----------------------------------------------------------------------------
// box_mean_filter_3x3_rgb
// 3x3 box mean over a raster stream of three-channel 8-bit pixels.
// ----------------------------------------------------------------------------
// Pixels enter in raster order, one per clock while pix_i.ready is high.
// Interior pixels leave as the per-channel 3x3 mean (sum / 9, truncated);
// first/last row and column pass through. Each result carries its
// coordinates and leaves one row and one column behind its input; the pixel
// that closes a row also sends the right column pixel above it, and
// bottom-row pixels go out at once, so one input gives zero to three words
// with run_last on the final one. The result port sends one word per cycle
// while res_o.ready is high, which sets the rate: a pixel with more words
// holds the input until its last word goes. A pixel passes the line store
// read, the window update and the result register, in that order. Two line
// stores of MAX_WIDTH entries hold the previous rows and need no clearing
// after reset. Writing image_width or image_height restarts the frame at
// column 0, row 0; values are clamped to 3..MAX_WIDTH and 3..MAX_HEIGHT.
module box_mean_filter_3x3_rgb #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 4096
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  bmf_pix_if.sink    pix_i,
  bmf_res_if.source  res_o,
  bmf_cfg_if.sink    cfg_i
);

  localparam int CW    = $clog2(MAX_WIDTH);
  localparam int RW    = $clog2(MAX_HEIGHT);
  localparam int RST_W = (MAX_WIDTH < bmf_pkg::WIDTH_RESET) ? MAX_WIDTH
                                                             : bmf_pkg::WIDTH_RESET;
  localparam int RST_H = (MAX_HEIGHT < bmf_pkg::HEIGHT_RESET) ? MAX_HEIGHT
                                                               : bmf_pkg::HEIGHT_RESET;
  localparam logic [CW-1:0] RST_COL_LAST = CW'(RST_W - 1);
  localparam logic [RW-1:0] RST_ROW_LAST = RW'(RST_H - 1);

  function automatic logic [CW-1:0] last_col(input logic [bmf_pkg::WIDTH_CFG_W-1:0] w);
    logic [31:0] v;
    v = 32'(w);
    if (v < 32'(bmf_pkg::DIM_MIN)) v = 32'(bmf_pkg::DIM_MIN);
    if (v > 32'(MAX_WIDTH)) v = 32'(MAX_WIDTH);
    return CW'(v - 32'd1);
  endfunction

  function automatic logic [RW-1:0] last_row(input logic [bmf_pkg::HEIGHT_CFG_W-1:0] h);
    logic [31:0] v;
    v = 32'(h);
    if (v < 32'(bmf_pkg::DIM_MIN)) v = 32'(bmf_pkg::DIM_MIN);
    if (v > 32'(MAX_HEIGHT)) v = 32'(MAX_HEIGHT);
    return RW'(v - 32'd1);
  endfunction

  logic [CW-1:0] col_last_q, col_last_d;
  logic [RW-1:0] row_last_q, row_last_d;
  logic [CW-1:0] col_q, col_d;
  logic [RW-1:0] row_q, row_d;
  logic          cfg_fire;
  logic          cfg_hit;

  logic          accept;
  logic          load;
  logic          load_ready;
  logic          restart;
  logic [CW-1:0] c_cur;
  logic [RW-1:0] r_cur;
  logic          at_col_end;
  logic          at_row_end;

  logic          s1_valid_q, s1_valid_d;
  bmf_pkg::rgb_t s1_pix_q;
  logic [CW-1:0] s1_col_q;
  logic [RW-1:0] s1_row_q;
  logic          s1_mean_q;
  logic          s1_right_q;
  logic          s1_bottom_q;
  logic          s1_border_q;

  bmf_pkg::rgb_t      pix_in;
  bmf_pkg::rgb_t      up_rd;
  bmf_pkg::rgb_t      mid_rd;
  bmf_pkg::bmf_item_t item;

  // configuration
  assign cfg_i.ready = 1'b1;
  assign cfg_fire    = cfg_i.valid && cfg_i.ready;

  always_comb begin
    col_last_d = col_last_q;
    row_last_d = row_last_q;
    cfg_hit    = 1'b0;
    if (cfg_fire) begin
      case (cfg_i.index)
        bmf_pkg::CFG_IMAGE_WIDTH: begin
          col_last_d = last_col(cfg_i.data[bmf_pkg::WIDTH_CFG_W-1:0]);
          cfg_hit    = 1'b1;
        end
        bmf_pkg::CFG_IMAGE_HEIGHT: begin
          row_last_d = last_row(cfg_i.data[bmf_pkg::HEIGHT_CFG_W-1:0]);
          cfg_hit    = 1'b1;
        end
        default: ;
      endcase
    end
  end

  // position of the incoming pixel
  assign accept     = pix_i.valid && pix_i.ready;
  assign restart    = (col_q > col_last_q) || (row_q > row_last_q);
  assign c_cur      = restart ? '0 : col_q;
  assign r_cur      = restart ? '0 : row_q;
  assign at_col_end = (c_cur == col_last_q);
  assign at_row_end = (r_cur == row_last_q);

  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (cfg_hit) begin
      col_d = '0;
      row_d = '0;
    end else if (accept) begin
      if (at_col_end) begin
        col_d = '0;
        row_d = at_row_end ? '0 : r_cur + RW'(1);
      end else begin
        col_d = c_cur + CW'(1);
        row_d = r_cur;
      end
    end
  end

  // stage 1 holds the pixel while the line stores are read
  assign load       = s1_valid_q && load_ready;
  assign pix_i.ready = !s1_valid_q || load_ready;
  assign pix_in     = {pix_i.chan2_in, pix_i.chan1_in, pix_i.chan0_in};

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (accept) begin
      s1_valid_d = 1'b1;
    end else if (load) begin
      s1_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_last_q <= RST_COL_LAST;
      row_last_q <= RST_ROW_LAST;
      col_q      <= '0;
      row_q      <= '0;
      s1_valid_q <= 1'b0;
    end else begin
      col_last_q <= col_last_d;
      row_last_q <= row_last_d;
      col_q      <= col_d;
      row_q      <= row_d;
      s1_valid_q <= s1_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_pix_q    <= pix_in;
      s1_col_q    <= c_cur;
      s1_row_q    <= r_cur;
      s1_mean_q   <= (r_cur != '0) && (c_cur != '0);
      s1_right_q  <= (r_cur != '0) && at_col_end;
      s1_bottom_q <= at_row_end;
      s1_border_q <= (c_cur == CW'(1)) || (r_cur == RW'(1));
    end
  end

  bmf_ram #(
    .WIDTH (bmf_pkg::RGB_W),
    .DEPTH (MAX_WIDTH)
  ) u_upper (
    .clk_i   (clk_i),
    .we_i    (load),
    .waddr_i (s1_col_q),
    .wdata_i (mid_rd),
    .re_i    (accept),
    .raddr_i (c_cur),
    .rdata_o (up_rd)
  );

  bmf_ram #(
    .WIDTH (bmf_pkg::RGB_W),
    .DEPTH (MAX_WIDTH)
  ) u_middle (
    .clk_i   (clk_i),
    .we_i    (load),
    .waddr_i (s1_col_q),
    .wdata_i (s1_pix_q),
    .re_i    (accept),
    .raddr_i (c_cur),
    .rdata_o (mid_rd)
  );

  always_comb begin
    item.pix         = s1_pix_q;
    item.up          = up_rd;
    item.mid         = mid_rd;
    item.col         = bmf_pkg::COL_W'(s1_col_q);
    item.row         = bmf_pkg::ROW_W'(s1_row_q);
    item.emit_mean   = s1_mean_q;
    item.emit_right  = s1_right_q;
    item.emit_bottom = s1_bottom_q;
    item.border      = s1_border_q;
  end

  bmf_emit u_emit (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_i       (item),
    .load_valid_i (s1_valid_q),
    .load_ready_o (load_ready),
    .res_o        (res_o)
  );

  // position counters never run past the frame
  a_pos_in_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (col_q <= col_last_q) && (row_q <= row_last_q))
    else $error("pixel position beyond frame size");

  a_cfg_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_hit |=> (col_q == '0) && (row_q == '0))
    else $error("register write did not restart the frame");

  // line store write and the next read never hit the same entry
  a_no_rw_clash: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (load && accept) |-> (s1_col_q != c_cur))
    else $error("line store read and write at the same column");

  a_s1_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && !load_ready) |=> s1_valid_q && $stable(s1_col_q))
    else $error("stage 1 pixel lost while results pending");

endmodule

// ===== test/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Drives raster pixels into box_mean_filter_3x3_rgb under several frame sizes,
// predicts each filtered or passed word with its coordinates and compares
// every word in order, with random idling both ways and a long receiver stall.
// ----------------------------------------------------------------------------
module testbench;
  import bmf_pkg::*;

  localparam int MAX_WIDTH      = 1024;
  localparam int MAX_HEIGHT     = 4096;
  localparam int GAP_PERCENT    = 11;
  localparam int RX_HOLD_CYCLES = 200;
  localparam int SETTLE_CYCLES  = 10;
  localparam int STALL_LIMIT    = 2000;

  localparam logic [CFG_IDX_W-1:0] CFG_UNMAPPED = 8'hFF;

  typedef struct {
    logic [PIX_W-1:0] chan0;
    logic [PIX_W-1:0] chan1;
    logic [PIX_W-1:0] chan2;
    logic [COL_W-1:0] col;
    logic [ROW_W-1:0] row;
    logic             last;
  } pixel_result_t;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  logic                  pix_valid = 1'b0;
  rgb_t                  pix_word  = '0;
  logic                  res_ready = 1'b0;
  logic                  cfg_valid = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;

  bmf_pix_if pix ();
  bmf_res_if res ();
  bmf_cfg_if cfg ();

  assign pix.valid    = pix_valid;
  assign pix.chan0_in = pix_word[7:0];
  assign pix.chan1_in = pix_word[15:8];
  assign pix.chan2_in = pix_word[23:16];
  assign res.ready    = res_ready;
  assign cfg.valid    = cfg_valid;
  assign cfg.index    = cfg_index;
  assign cfg.data     = cfg_data;

  box_mean_filter_3x3_rgb #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .pix_i  (pix),
    .res_o  (res),
    .cfg_i  (cfg)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // filter state as seen from outside
  logic [WIDTH_CFG_W-1:0]  width_reg  = WIDTH_CFG_W'(WIDTH_RESET);
  logic [HEIGHT_CFG_W-1:0] height_reg = HEIGHT_CFG_W'(HEIGHT_RESET);
  rgb_t                    row_above  [MAX_WIDTH];
  rgb_t                    row_middle [MAX_WIDTH];
  rgb_t                    window     [9];
  int unsigned             col_pos = 0;
  int unsigned             row_pos = 0;

  rgb_t          raster_q[$];
  pixel_result_t filtered_q[$];

  int mismatches    = 0;
  int hold_requests = 0;
  bit use_gaps      = 1'b1;

  function automatic int unsigned clamp_dim(input int unsigned v, input int unsigned hi);
    if (v < DIM_MIN) return DIM_MIN;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic rgb_t window_mean();
    rgb_t        m;
    int unsigned sum;
    m = '0;
    for (int ch = 0; ch < CH_N; ch++) begin
      sum = 0;
      for (int k = 0; k < 9; k++) sum += window[k][PIX_W*ch +: PIX_W];
      m[PIX_W*ch +: PIX_W] = PIX_W'(sum / 9);
    end
    return m;
  endfunction

  function automatic pixel_result_t make_result(input rgb_t v, input int unsigned c,
                                                input int unsigned r);
    pixel_result_t o;
    o.chan0 = v[7:0];
    o.chan1 = v[15:8];
    o.chan2 = v[23:16];
    o.col   = COL_W'(c);
    o.row   = ROW_W'(r);
    o.last  = 1'b0;
    return o;
  endfunction

  task automatic filter_pixel(input rgb_t px);
    int unsigned   w, h, c, r;
    rgb_t          up, mid;
    pixel_result_t outs [3];
    int            n;
    w = clamp_dim(32'(width_reg), MAX_WIDTH);
    h = clamp_dim(32'(height_reg), MAX_HEIGHT);
    c = col_pos;
    r = row_pos;
    n = 0;
    if (c >= w || r >= h) begin
      c = 0;
      r = 0;
    end
    up  = row_above[c];
    mid = row_middle[c];
    // new right column holds rows r-2, r-1 and r
    window[0] = window[1]; window[1] = window[2]; window[2] = up;
    window[3] = window[4]; window[4] = window[5]; window[5] = mid;
    window[6] = window[7]; window[7] = window[8]; window[8] = px;
    row_above[c]  = mid;
    row_middle[c] = px;
    if (r >= 1 && c >= 1) begin
      outs[n] = make_result((c == 1 || r == 1) ? window[4] : window_mean(), c - 1, r - 1);
      n++;
    end
    if (r >= 1 && c == w - 1) begin
      outs[n] = make_result(mid, c, r - 1);
      n++;
    end
    if (r == h - 1) begin
      outs[n] = make_result(px, c, r);
      n++;
    end
    for (int i = 0; i < n; i++) begin
      outs[i].last = (i == n - 1);
      filtered_q.push_back(outs[i]);
    end
    c++;
    if (c >= w) begin
      c = 0;
      r++;
      if (r >= h) r = 0;
    end
    col_pos = c;
    row_pos = r;
  endtask

  function automatic logic [PIX_W-1:0] rand_byte();
    case ($urandom_range(7))
      0: return 8'h00;
      1: return 8'hFF;
      default: return PIX_W'($urandom_range(255));
    endcase
  endfunction

  task automatic push_random(input int n);
    repeat (n) raster_q.push_back({rand_byte(), rand_byte(), rand_byte()});
  endtask

  task automatic wait_idle();
    while (raster_q.size() != 0 || pix_valid || filtered_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg.ready);
    cfg_valid <= 1'b0;
    // any write to a real register restarts the frame
    if (idx == CFG_IMAGE_WIDTH) begin
      width_reg = val[WIDTH_CFG_W-1:0];
      col_pos   = 0;
      row_pos   = 0;
    end else if (idx == CFG_IMAGE_HEIGHT) begin
      height_reg = val[HEIGHT_CFG_W-1:0];
      col_pos    = 0;
      row_pos    = 0;
    end
  endtask

  task automatic start_frame(input logic [CFG_DATA_W-1:0] w, input logic [CFG_DATA_W-1:0] h);
    wait_idle();
    write_reg(CFG_IMAGE_WIDTH, w);
    write_reg(CFG_IMAGE_HEIGHT, h);
  endtask

  task automatic compare_field(input string name, input int unsigned want,
                               input int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, actual %0d", name, want, got);
      mismatches++;
    end
  endtask

  // pixel driver: the front of raster_q is the word on offer
  always @(posedge clk) begin
    if (!rst_n) begin
      pix_valid <= 1'b0;
    end else begin
      if (pix_valid && pix.ready) begin
        filter_pixel(pix_word);
        void'(raster_q.pop_front());
      end
      if (!pix_valid || pix.ready) begin
        if (raster_q.size() != 0 && !(use_gaps && $urandom_range(99) < GAP_PERCENT)) begin
          pix_valid <= 1'b1;
          pix_word  <= raster_q[0];
        end else begin
          pix_valid <= 1'b0;
        end
      end
    end
  end

  // result monitor
  pixel_result_t got_word;
  pixel_result_t want_word;
  int            holds_served = 0;
  int            hold_left    = 0;

  always @(posedge clk) begin
    if (!rst_n) begin
      res_ready <= 1'b0;
    end else begin
      if (res.valid && res_ready) begin
        got_word.chan0 = res.chan0_out;
        got_word.chan1 = res.chan1_out;
        got_word.chan2 = res.chan2_out;
        got_word.col   = res.out_col;
        got_word.row   = res.out_row;
        got_word.last  = res.run_last;
        if (filtered_q.size() == 0) begin
          $error("unexpected word at col %0d row %0d", got_word.col, got_word.row);
          mismatches++;
        end else begin
          want_word = filtered_q.pop_front();
          compare_field("chan0_out", 32'(want_word.chan0), 32'(got_word.chan0));
          compare_field("chan1_out", 32'(want_word.chan1), 32'(got_word.chan1));
          compare_field("chan2_out", 32'(want_word.chan2), 32'(got_word.chan2));
          compare_field("out_col", 32'(want_word.col), 32'(got_word.col));
          compare_field("out_row", 32'(want_word.row), 32'(got_word.row));
          compare_field("run_last", 32'(want_word.last), 32'(got_word.last));
        end
      end
      if (hold_requests != holds_served) begin
        holds_served = hold_requests;
        hold_left    = RX_HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        res_ready <= 1'b0;
      end else begin
        res_ready <= !(use_gaps && $urandom_range(99) < GAP_PERCENT);
      end
    end
  end

  // watchdog on cycles with no handshake at all
  int stall_cycles = 0;

  always @(posedge clk) begin
    if (!rst_n || (pix_valid && pix.ready) || (res.valid && res_ready) ||
        (cfg_valid && cfg.ready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (stall_cycles >= STALL_LIMIT) begin
      $display("FAIL box_mean_filter_3x3_rgb");
      $finish;
    end
  end

  initial begin : main
    int unsigned w, h;
    foreach (row_above[i]) begin
      row_above[i]  = '0;
      row_middle[i] = '0;
    end
    foreach (window[i]) window[i] = '0;

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    repeat (2) @(posedge clk);

    // smallest frame, both registers below range
    write_reg(CFG_IMAGE_WIDTH, 16'h0000);
    write_reg(CFG_IMAGE_HEIGHT, 16'h0002);
    repeat (9) raster_q.push_back(24'hFFFFFF);
    // second frame right after the wrap
    for (int i = 0; i < 9; i++) raster_q.push_back((i % 2) ? 24'hFF00FF : 24'h00FF00);

    // upper data bits are dropped by the registers
    start_frame(16'hF805, 16'hE004);
    raster_q.push_back(24'h000000);
    raster_q.push_back(24'hFFFFFF);
    raster_q.push_back(24'h00FFFF);
    raster_q.push_back(24'hFF0000);
    raster_q.push_back(24'h123456);
    raster_q.push_back(24'hFEDCBA);
    raster_q.push_back(24'h0F0F0F);

    // unmapped index leaves the frame position alone
    wait_idle();
    write_reg(CFG_UNMAPPED, 16'hFFFF);
    push_random(20);
    // sender waits for every word of the frame
    wait_idle();
    push_random(30);

    // widest row, clamped to the line store depth
    start_frame(16'h07FF, 16'd3);
    push_random(24);

    // a whole frame with no idling anywhere
    start_frame(16'd12, 16'd5);
    use_gaps = 1'b0;
    push_random(60);
    wait_idle();
    use_gaps = 1'b1;

    // tallest frame
    start_frame(16'd3, 16'h1FFF);
    push_random(30);

    // receiver stalls while the sender keeps offering words
    start_frame(16'd16, 16'd5);
    hold_requests++;
    push_random(80);

    start_frame(16'd1, 16'd1);
    push_random(27);

    repeat (2) begin
      w = $urandom_range(12, 3);
      h = $urandom_range(7, 3);
      start_frame(CFG_DATA_W'(w), CFG_DATA_W'(h));
      push_random(w * h + $urandom_range(w, 0));
    end

    wait_idle();
    if (mismatches == 0 && filtered_q.size() == 0) begin
      $display("PASS box_mean_filter_3x3_rgb");
    end else begin
      if (filtered_q.size() != 0) $error("%0d words never arrived", filtered_q.size());
      $display("FAIL box_mean_filter_3x3_rgb");
    end
    $finish;
  end

endmodule
